// ----- src/tmdf_pkg.sv -----
// ----------------------------------------------------------------------------
// tmdf_pkg
// Types, constants and compare helpers of the temporal median depth filter.
// ----------------------------------------------------------------------------
package tmdf_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int MAX_PIXELS  = 524288;
    localparam int POS_W       = $clog2(MAX_PIXELS);
    localparam int FILL_W      = POS_W + 1;
    localparam int DEPTH_W     = 16;
    localparam int CNT_W       = 4;
    localparam int FRAME_W     = 20;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // one memory row per pixel position
    typedef struct packed {
        depth_t [MAX_WINDOW-1:0] hist;
        slot_t  [MAX_WINDOW-1:0] rank;
        cnt_t                    tally;
    } row_t;

    // register select taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_FRAME  = 1'b1;

    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(307200);
    localparam logic [FRAME_W-1:0] FRAME_MAX   = FRAME_W'(MAX_PIXELS);
    localparam cnt_t               WIN_MAX     = CNT_W'(MAX_WINDOW);

    // zero is invalid and ranks above every valid value
    function automatic logic order_gt(input depth_t x, input depth_t y);
        logic res;
        if (x == '0) begin
            res = (y != '0);
        end else begin
            res = (y != '0) && (x > y);
        end
        return res;
    endfunction

    function automatic logic order_lt(input depth_t x, input depth_t y);
        return order_gt(y, x);
    endfunction

endpackage

// ----- src/temporal_median_depth_filter_top.sv -----
// ----------------------------------------------------------------------------
// temporal_median_depth_filter_top
// Per-pixel temporal median of a raster depth stream.
//
//   channel | dir | fields
//   s_      | in  | depth_in (16)
//   m_      | out | median_depth (16), valid_count (4), frame_end (1)
//   apb     | in  | window_length @0x0, frame_pixels @0x4
//
// One pixel per cycle unless m_ready stalls or a row hazard holds; each request
// passes row read, compare, reorder and write back, and the output register.
// A pixel whose row is still in flight (frames of one or two pixels) waits
// until the write back of the earlier request.
// No clearing pass: a fill count marks rows written since the last restart.
// A stall at m_ready freezes every stage; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module temporal_median_depth_filter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tmdf_pkg::ADDR_W-1:0]       paddr,
    input  logic [tmdf_pkg::DATA_W-1:0]       pwdata,
    output logic [tmdf_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tmdf_pkg::DEPTH_W-1:0]      s_depth_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tmdf_pkg::DEPTH_W-1:0]      m_median_depth,
    output logic [tmdf_pkg::CNT_W-1:0]        m_valid_count,
    output logic                              m_frame_end
);
    import tmdf_pkg::*;

    // control
    cnt_t                 win_reg;
    logic [FRAME_W-1:0]   frame_reg;
    slot_t                oldest_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;

    logic                 cfg_wr;
    cnt_t                 win_next;
    logic [FRAME_W-1:0]   frame_next;
    logic                 adv, hazard, acc;
    cnt_t                 oldest_step;
    slot_t                cur_slot;
    logic [FRAME_W-1:0]   pos_inc;
    logic                 cur_last;

    // memory
    row_t                 mem [MAX_PIXELS];
    row_t                 rd_reg;
    row_t                 wr_row;

    // stage A
    logic [POS_W-1:0]     a_pos_reg;
    slot_t                a_slot_reg;
    depth_t               a_nv_reg;
    logic                 a_last_reg;
    logic                 a_ok_reg;

    // stage B
    depth_t [MAX_WINDOW-1:0] b_hist_reg;
    slot_t  [MAX_WINDOW-1:0] b_rank_reg;
    cnt_t                 b_tally_reg;
    depth_t               b_nv_reg;
    slot_t                b_slot_reg;
    slot_t                b_j_reg;
    logic [MAX_WINDOW-1:0] b_gtp_reg, b_ltp_reg;
    logic                 b_relgt_reg, b_rellt_reg, b_ovz_reg;
    logic [POS_W-1:0]     b_pos_reg;
    logic                 b_last_reg;

    // stage C
    depth_t [MAX_WINDOW-1:0] c_hist_reg;
    slot_t  [MAX_WINDOW-1:0] c_rank_reg;
    slot_t                c_mid_reg;
    cnt_t                 c_v_reg;
    logic                 c_last_reg;

    // output
    depth_t               m_med_reg;
    cnt_t                 m_cnt_reg;
    logic                 m_end_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        win_next = pwdata[CNT_W-1:0];
        if (win_next == '0) begin
            win_next = CNT_W'(1);
        end else if (win_next > WIN_MAX) begin
            win_next = WIN_MAX;
        end
        frame_next = pwdata[FRAME_W-1:0];
        if (frame_next == '0) begin
            frame_next = FRAME_W'(1);
        end else if (frame_next > FRAME_MAX) begin
            frame_next = FRAME_MAX;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_WINDOW: prdata = DATA_W'(win_reg);
            REG_FRAME:  prdata = DATA_W'(frame_reg);
            default:    prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    assign adv    = !m_valid_reg || m_ready;
    assign hazard = (a_valid_reg && (a_pos_reg == pos_reg)) ||
                    (b_valid_reg && (b_pos_reg == pos_reg));
    assign s_ready = adv && !hazard;
    assign acc     = s_valid && s_ready;

    always_comb begin
        oldest_step = CNT_W'(oldest_reg) + CNT_W'(1);
        if (oldest_step >= win_reg) begin
            oldest_step = '0;
        end
        cur_slot = (pos_reg == '0) ? oldest_step[SLOT_W-1:0] : oldest_reg;
        if (CNT_W'(cur_slot) >= win_reg) begin
            cur_slot = '0;
        end
        pos_inc  = FRAME_W'(pos_reg) + FRAME_W'(1);
        cur_last = (pos_inc >= frame_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= CNT_W'(1);
            frame_reg   <= FRAME_RESET;
            oldest_reg  <= '0;
            pos_reg     <= '0;
            fill_reg    <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_WINDOW: begin
                        win_reg    <= win_next;
                        oldest_reg <= SLOT_W'(win_next - CNT_W'(1));
                        pos_reg    <= '0;
                        fill_reg   <= '0;
                    end
                    REG_FRAME: begin
                        frame_reg <= frame_next;
                    end
                    default: begin
                        frame_reg <= frame_reg;
                    end
                endcase
            end else if (acc) begin
                pos_reg <= cur_last ? '0 : pos_inc[POS_W-1:0];
                if (pos_reg == '0) begin
                    oldest_reg <= oldest_step[SLOT_W-1:0];
                end
                if (FILL_W'(pos_reg) == fill_reg) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
            end
            if (adv) begin
                a_valid_reg <= acc;
                b_valid_reg <= a_valid_reg;
                c_valid_reg <= b_valid_reg;
                m_valid_reg <= c_valid_reg;
            end
        end
    end

    // ---------------- row memory ----------------
    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg <= mem[pos_reg];
        end
        if (adv && b_valid_reg) begin
            mem[b_pos_reg] <= wr_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_pos_reg  <= pos_reg;
            a_slot_reg <= cur_slot;
            a_nv_reg   <= s_depth_in;
            a_last_reg <= cur_last;
            a_ok_reg   <= (FILL_W'(pos_reg) < fill_reg);
        end
    end

    // ---------------- stage B: compares ----------------
    row_t                  a_row;
    logic [MAX_WINDOW-1:0] gt_s, lt_s, gt_p, lt_p;
    slot_t                 j_a;

    always_comb begin
        if (a_ok_reg) begin
            a_row = rd_reg;
        end else begin
            a_row.hist  = '0;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                a_row.rank[i] = SLOT_W'(i);
            end
            a_row.tally = win_reg;
        end
        j_a = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            gt_s[i] = order_gt(a_nv_reg, a_row.hist[i]);
            lt_s[i] = order_lt(a_nv_reg, a_row.hist[i]);
        end
        for (int k = 0; k < MAX_WINDOW; k++) begin
            gt_p[k] = (CNT_W'(k) < win_reg) && gt_s[a_row.rank[k]];
            lt_p[k] = (CNT_W'(k) < win_reg) && lt_s[a_row.rank[k]];
            if ((CNT_W'(k) < win_reg) && (a_row.rank[k] == a_slot_reg)) begin
                j_a = j_a | SLOT_W'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_hist_reg  <= a_row.hist;
            b_rank_reg  <= a_row.rank;
            b_tally_reg <= a_row.tally;
            b_nv_reg    <= a_nv_reg;
            b_slot_reg  <= a_slot_reg;
            b_j_reg     <= j_a;
            b_gtp_reg   <= gt_p;
            b_ltp_reg   <= lt_p;
            b_relgt_reg <= gt_s[a_slot_reg];
            b_rellt_reg <= lt_s[a_slot_reg];
            b_ovz_reg   <= (a_row.hist[a_slot_reg] == '0);
            b_pos_reg   <= a_pos_reg;
            b_last_reg  <= a_last_reg;
        end
    end

    // ---------------- stage C: reorder, tally, write back ----------------
    cnt_t                    n_up, n_dn, t_pos, tally_new, v_new;
    slot_t                   t_idx;
    slot_t  [MAX_WINDOW-1:0] rank_new;
    depth_t [MAX_WINDOW-1:0] hist_new;

    always_comb begin
        n_up = '0;
        n_dn = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if ((SLOT_W'(k) > b_j_reg) && b_gtp_reg[k]) begin
                n_up = n_up + CNT_W'(1);
            end
            if ((SLOT_W'(k) < b_j_reg) && b_ltp_reg[k]) begin
                n_dn = n_dn + CNT_W'(1);
            end
        end
        priority if (b_relgt_reg) begin
            t_pos = CNT_W'(b_j_reg) + n_up;
        end else if (b_rellt_reg) begin
            t_pos = CNT_W'(b_j_reg) - n_dn;
        end else begin
            t_pos = CNT_W'(b_j_reg);
        end
        t_idx = t_pos[SLOT_W-1:0];

        // remove at j, insert at t
        for (int i = 0; i < MAX_WINDOW; i++) begin
            rank_new[i] = b_rank_reg[i];
            if (b_relgt_reg && (i < MAX_WINDOW - 1) && (SLOT_W'(i) >= b_j_reg) &&
                (SLOT_W'(i) < t_idx)) begin
                rank_new[i] = b_rank_reg[(i + 1) % MAX_WINDOW];
            end
            if (b_rellt_reg && (i > 0) && (SLOT_W'(i) > t_idx) &&
                (SLOT_W'(i) <= b_j_reg)) begin
                rank_new[i] = b_rank_reg[(i + MAX_WINDOW - 1) % MAX_WINDOW];
            end
            if (SLOT_W'(i) == t_idx) begin
                rank_new[i] = b_slot_reg;
            end
        end

        tally_new = b_tally_reg;
        if ((b_nv_reg == '0) && !b_ovz_reg && (b_tally_reg < win_reg)) begin
            tally_new = b_tally_reg + CNT_W'(1);
        end else if ((b_nv_reg != '0) && b_ovz_reg && (b_tally_reg != '0)) begin
            tally_new = b_tally_reg - CNT_W'(1);
        end
        if (tally_new > win_reg) begin
            tally_new = win_reg;
        end
        v_new = win_reg - tally_new;

        hist_new             = b_hist_reg;
        hist_new[b_slot_reg] = b_nv_reg;

        wr_row.hist  = hist_new;
        wr_row.rank  = rank_new;
        wr_row.tally = tally_new;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_hist_reg <= hist_new;
            c_rank_reg <= rank_new;
            c_mid_reg  <= v_new[SLOT_W:1];
            c_v_reg    <= v_new;
            c_last_reg <= b_last_reg;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_med_reg <= c_hist_reg[c_rank_reg[c_mid_reg]];
            m_cnt_reg <= c_v_reg;
            m_end_reg <= c_last_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_median_depth = m_med_reg;
    assign m_valid_count  = m_cnt_reg;
    assign m_frame_end    = m_end_reg;

`ifndef NO_ASSERTIONS
    a_no_row_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && b_valid_reg) |-> (a_pos_reg != b_pos_reg))
        else $error("two requests on one row in flight");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        c_valid_reg |-> (c_v_reg <= win_reg))
        else $error("valid count above window length");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_PIXELS))
        else $error("fill count overflow");

    a_oldest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && (pos_reg == '0)) |=> (CNT_W'(oldest_reg) < win_reg))
        else $error("oldest slot outside window");
`endif

endmodule
